// ===== hw/rtl/lfpu_pkg.sv =====
// Shared types and constants for the leapfrog particle update block.
`default_nettype none

package lfpu_pkg;

    // Lambda table geometry (power of two, indexed by the low group bits)
    localparam int NUM_GROUPS = 64;
    localparam int LAMBDA_AW  = $clog2(NUM_GROUPS);
    localparam int LAMBDA_W   = 18;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PR_DIAG_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PR_DIAG_Y     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PR_DIAG_Z     = 3'd5;

    localparam logic [31:0] TIME_STEP_RESET = 32'd8589935;

    // temp_mode codes; the unused code behaves as no scaling
    localparam logic [1:0] TEMP_NONE   = 2'd0;
    localparam logic [1:0] TEMP_SINGLE = 2'd1;
    localparam logic [1:0] TEMP_GROUP  = 2'd2;

    // func codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    // axis codes; the unused code gets no pressure term
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic                func;
        logic [1:0]          axis;
        logic [5:0]          group;
        logic [17:0]         lambda_value;
        logic signed [31:0]  position;
        logic signed [31:0]  velocity;
        logic signed [31:0]  force_req;
        logic [31:0]         inv_mass;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0]  new_position;
        logic signed [31:0]  new_velocity;
        logic signed [31:0]  old_position;
        logic                overflow;
    } t_out_word;

endpackage

`default_nettype wire

// ===== hw/rtl/lfpu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lfpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/leapfrog_particle_update.sv =====
// Top level of the leapfrog particle update: six-stage fixed-point pipeline.
`default_nettype none

//  channel   direction  handshake                    payload
//  in        sink       i_in_valid / o_in_stall      i_in_word  (t_in_word)
//  out       source     o_out_valid / i_out_stall    o_out_word (t_out_word)
//  cfg       sink       i_cfg_we                     i_cfg_index, i_cfg_data
//
//  One word per cycle in and out unless stalled. An integrate word passes stages 1-6;
//  a load word writes the lambda RAM in its accept cycle and yields nothing.
//  The depth is set by the multiplier chain: f*m, then (f*m)*dt, then v*dt.
//  Reset (sync, active low) sets config to its reset values and clears stage valids; lambda RAM is not cleared.
//  Each stage moves when it is empty or the next one moves, so bubbles close up
//  and the input is only stalled when every stage holds a word.

module leapfrog_particle_update (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire lfpu_pkg::t_in_word               i_in_word,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output lfpu_pkg::t_out_word                   o_out_word,
    input  wire logic                             i_cfg_we,
    input  wire logic [lfpu_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [lfpu_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import lfpu_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [31:0] r_time_step;
    logic [1:0]  r_temp_mode;
    logic        r_pressure_mode;
    logic [31:0] r_pr_x;
    logic [31:0] r_pr_y;
    logic [31:0] r_pr_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step     <= TIME_STEP_RESET;
            r_temp_mode     <= TEMP_NONE;
            r_pressure_mode <= 1'b0;
            r_pr_x          <= '0;
            r_pr_y          <= '0;
            r_pr_z          <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TIME_STEP:     r_time_step     <= i_cfg_data[31:0];
                CFG_TEMP_MODE:     r_temp_mode     <= i_cfg_data[1:0];
                CFG_PRESSURE_MODE: r_pressure_mode <= i_cfg_data[0];
                CFG_PR_DIAG_X:     r_pr_x          <= i_cfg_data[31:0];
                CFG_PR_DIAG_Y:     r_pr_y          <= i_cfg_data[31:0];
                CFG_PR_DIAG_Z:     r_pr_z          <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stage flow control
    // ---------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic en1, en2, en3, en4, en5, en6;
    logic in_accept;

    assign en6       = !r_v6 || !i_out_stall;
    assign en5       = !r_v5 || en6;
    assign en4       = !r_v4 || en5;
    assign en3       = !r_v3 || en4;
    assign en2       = !r_v2 || en3;
    assign en1       = !r_v1 || en2;
    assign o_in_stall = !en1;
    assign in_accept = i_in_valid && en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en1) r_v1 <= in_accept && (i_in_word.func == FUNC_STEP);
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
            if (en6) r_v6 <= r_v5;
        end
    end

    // ---------------------------------------------------------------
    // Lambda table: written by load words, read for integrate words.
    // Read data lands while the word sits in stage 1 and holds while it stalls.
    // ---------------------------------------------------------------
    logic                 lam_we;
    logic                 lam_re;
    logic [LAMBDA_AW-1:0] lam_raddr;
    logic [LAMBDA_W-1:0]  lam_rdata;

    assign lam_we    = in_accept && (i_in_word.func == FUNC_LOAD);
    assign lam_re    = in_accept && (i_in_word.func == FUNC_STEP);
    assign lam_raddr = (r_temp_mode == TEMP_SINGLE) ? '0 : i_in_word.group[LAMBDA_AW-1:0];

    lfpu_ram #(
        .WIDTH (LAMBDA_W),
        .DEPTH (NUM_GROUPS)
    ) u_lambda_ram (
        .i_clk   (i_clk),
        .i_we    (lam_we),
        .i_waddr (i_in_word.group[LAMBDA_AW-1:0]),
        .i_wdata (i_in_word.lambda_value),
        .i_re    (lam_re),
        .i_raddr (lam_raddr),
        .o_rdata (lam_rdata)
    );

    // ---------------------------------------------------------------
    // Stage 1: magnitudes, |f|*inv_mass, |pr|*|v| >> 30
    // ---------------------------------------------------------------
    logic [31:0] n_fmag, n_vmag, n_prmag, n_pr;
    logic [63:0] n_fm_prod, n_pr_prod;
    logic        n_lam_en;

    always_comb begin
        n_fmag = i_in_word.force_req[31] ? (32'd0 - i_in_word.force_req)
                                         : i_in_word.force_req;
        n_vmag = i_in_word.velocity[31] ? (32'd0 - i_in_word.velocity)
                                        : i_in_word.velocity;
        unique case (i_in_word.axis)
            AXIS_X:  n_pr = r_pr_x;
            AXIS_Y:  n_pr = r_pr_y;
            AXIS_Z:  n_pr = r_pr_z;
            default: n_pr = '0;
        endcase
        if (!r_pressure_mode) begin
            n_pr = '0;
        end
        n_prmag   = n_pr[31] ? (32'd0 - n_pr) : n_pr;
        n_fm_prod = {32'd0, n_fmag} * {32'd0, i_in_word.inv_mass};
        n_pr_prod = {32'd0, n_prmag} * {32'd0, n_vmag};
        n_lam_en  = (r_temp_mode == TEMP_SINGLE) || (r_temp_mode == TEMP_GROUP);
    end

    logic [31:0] r_s1_x, r_s1_v, r_s1_vmag;
    logic        r_s1_vneg, r_s1_lam_en, r_s1_fneg, r_s1_pneg;
    logic [62:0] r_s1_fm;
    logic [32:0] r_s1_pmag;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_x      <= i_in_word.position;
            r_s1_v      <= i_in_word.velocity;
            r_s1_vmag   <= n_vmag;
            r_s1_vneg   <= i_in_word.velocity[31];
            r_s1_lam_en <= n_lam_en;
            r_s1_fneg   <= i_in_word.force_req[31];
            r_s1_fm     <= n_fm_prod[62:0];
            r_s1_pmag   <= n_pr_prod[62:30];
            r_s1_pneg   <= n_pr[31] ^ i_in_word.velocity[31];
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: v*lambda >> 16 (v unscaled if lambda off), signed pressure term, fm split times dt
    // ---------------------------------------------------------------
    logic [49:0] n_vl_prod;
    logic [32:0] n_vl_mag;
    logic [33:0] n_vs, n_pt;
    logic [63:0] n_hts_prod, n_lts_prod;

    always_comb begin
        n_vl_prod  = {18'd0, r_s1_vmag} * {32'd0, lam_rdata};
        n_vl_mag   = n_vl_prod[48:16];
        if (r_s1_lam_en) begin
            n_vs = r_s1_vneg ? (34'd0 - {1'b0, n_vl_mag}) : {1'b0, n_vl_mag};
        end else begin
            n_vs = {{2{r_s1_v[31]}}, r_s1_v};
        end
        n_pt       = r_s1_pneg ? (34'd0 - {1'b0, r_s1_pmag}) : {1'b0, r_s1_pmag};
        n_hts_prod = {33'd0, r_s1_fm[62:32]} * {32'd0, r_time_step};
        n_lts_prod = {32'd0, r_s1_fm[31:0]} * {32'd0, r_time_step};
    end

    logic [31:0] r_s2_x, r_s2_lts;
    logic [33:0] r_s2_vs, r_s2_pt;
    logic [62:0] r_s2_hts;
    logic        r_s2_fneg;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_x    <= r_s1_x;
            r_s2_vs   <= n_vs;
            r_s2_pt   <= n_pt;
            r_s2_hts  <= n_hts_prod[62:0];
            r_s2_lts  <= n_lts_prod[63:32];
            r_s2_fneg <= r_s1_fneg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: q = (f*m*dt) >> 48, vp = scaled v - pressure term
    // ---------------------------------------------------------------
    logic [63:0] n_q_sum;
    logic [34:0] n_vp;

    always_comb begin
        n_q_sum = {1'b0, r_s2_hts} + {32'd0, r_s2_lts};
        n_vp    = {r_s2_vs[33], r_s2_vs} - {r_s2_pt[33], r_s2_pt};
    end

    logic [31:0] r_s3_x;
    logic [46:0] r_s3_q;
    logic [34:0] r_s3_vp;
    logic        r_s3_fneg;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_x    <= r_s2_x;
            r_s3_q    <= n_q_sum[62:16];
            r_s3_vp   <= n_vp;
            r_s3_fneg <= r_s2_fneg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: new velocity, saturated
    // ---------------------------------------------------------------
    logic [47:0] n_qs;
    logic [48:0] n_vsum;
    logic        n_v_fits;
    logic [31:0] n_vnew;

    always_comb begin
        n_qs     = r_s3_fneg ? (48'd0 - {1'b0, r_s3_q}) : {1'b0, r_s3_q};
        n_vsum   = {{14{r_s3_vp[34]}}, r_s3_vp} + {n_qs[47], n_qs};
        n_v_fits = (&n_vsum[48:31]) || !(|n_vsum[48:31]);
        if (n_v_fits) begin
            n_vnew = n_vsum[31:0];
        end else begin
            n_vnew = n_vsum[48] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    logic [31:0] r_s4_x, r_s4_vnew;
    logic        r_s4_ovf;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_s4_x    <= r_s3_x;
            r_s4_vnew <= n_vnew;
            r_s4_ovf  <= !n_v_fits;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: position increment = new velocity * dt >> 32, toward zero
    // ---------------------------------------------------------------
    logic [31:0] n_vnmag;
    logic [63:0] n_dx_prod;
    logic [32:0] n_dx;

    always_comb begin
        n_vnmag   = r_s4_vnew[31] ? (32'd0 - r_s4_vnew) : r_s4_vnew;
        n_dx_prod = {32'd0, n_vnmag} * {32'd0, r_time_step};
        n_dx      = r_s4_vnew[31] ? (33'd0 - {1'b0, n_dx_prod[63:32]})
                                  : {1'b0, n_dx_prod[63:32]};
    end

    logic [31:0] r_s5_x, r_s5_vnew;
    logic [32:0] r_s5_dx;
    logic        r_s5_ovf;

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_s5_x    <= r_s4_x;
            r_s5_vnew <= r_s4_vnew;
            r_s5_dx   <= n_dx;
            r_s5_ovf  <= r_s4_ovf;
        end
    end

    // ---------------------------------------------------------------
    // Stage 6 (output register): new position, saturated
    // ---------------------------------------------------------------
    logic [33:0] n_xsum;
    logic        n_x_fits;
    logic [31:0] n_xnew;

    always_comb begin
        n_xsum   = {{2{r_s5_x[31]}}, r_s5_x} + {r_s5_dx[32], r_s5_dx};
        n_x_fits = (&n_xsum[33:31]) || !(|n_xsum[33:31]);
        if (n_x_fits) begin
            n_xnew = n_xsum[31:0];
        end else begin
            n_xnew = n_xsum[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    t_out_word r_out_word;

    always_ff @(posedge i_clk) begin
        if (en6) begin
            r_out_word.new_position <= n_xnew;
            r_out_word.new_velocity <= r_s5_vnew;
            r_out_word.old_position <= r_s5_x;
            r_out_word.overflow     <= r_s5_ovf || !n_x_fits;
        end
    end

    assign o_out_valid = r_v6;
    assign o_out_word  = r_out_word;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // a load word never enters the datapath
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_in_word.func == FUNC_LOAD)) |=> !r_v1)
        else $error("load word entered the pipeline");

    // input only stalls when every stage is full and the output is blocked
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && r_v6 && i_out_stall))
        else $error("input stalled with a bubble in the pipeline");

    // a word held in stage 1 keeps its lambda read data
    a_lambda_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !en2) |=> (r_v1 && $stable(lam_rdata)))
        else $error("lambda read data changed under a stalled word");

endmodule

`default_nettype wire
